/* hdl/ffha_pkg.sv */
// Package for the first-fit heap allocator: constants, payload structs,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package ffha_pkg;

  localparam int unsigned MaxSegments = 64;
  localparam logic [31:0] HeapSizeReset = 32'd65536;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] request_size;
    logic [31:0] release_offset;
  } in_item_t;

  typedef struct packed {
    logic [31:0] granted_offset;
    logic [1:0]  status;
    logic [31:0] bytes_in_use;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_SHIFT_RD,
    S_A_SHIFT_WR,
    S_A_FIN,
    S_F_RD,
    S_F_CHK,
    S_M_RD,
    S_M_STEP,
    S_M_FLUSH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic init;       // reinitialize table
    logic start;      // latch request, clear scan
    logic a_check;    // evaluate allocate entry
    logic sh_rd;      // read entry j-1
    logic sh_wr;      // write entry j
    logic a_resize;   // resize hit entry, mark it owned
    logic a_fin;      // write split remainder
    logic f_check;    // evaluate free entry
    logic m_start;    // start merge
    logic m_step;     // one merge step
    logic m_flush;    // write pending merge entry
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic pre_fail;    // zero request or free total too small
    logic scan_end;    // index reached count
    logic a_hit;       // entry fits
    logic a_exact;
    logic a_full;
    logic sh_done;
    logic f_stop;      // free scan ends at this entry
    logic m_end;
  } stat_t;

endpackage

/* hdl/ffha_datapath.sv */
// Datapath of the first-fit heap allocator: segment memory (size and owned
// mark), scan counters, running offset and result registers. Uses ffha_pkg.
module ffha_datapath #(
  parameter int unsigned MAX_SEGMENTS = ffha_pkg::MaxSegments
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffha_pkg::cmd_t      cmd,
  output ffha_pkg::stat_t     stat,
  input  ffha_pkg::in_item_t  in_item,
  input  logic [31:0]         heap_size,
  output ffha_pkg::out_item_t result
);
  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

  logic [32:0] mem [MAX_SEGMENTS];
  logic [32:0] rdata_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] total_r, total_nxt;
  ffha_pkg::in_item_t req_r;
  logic [CW-1:0] idx_r, idx_nxt;     // scan / read pointer
  logic [CW-1:0] wr_r, wr_nxt;       // merge write pointer
  logic [32:0] off_r, off_nxt;
  logic [31:0] acc_r, acc_nxt;       // pending merge size
  logic acc_own_r, acc_own_nxt;
  logic acc_vld_r, acc_vld_nxt;
  logic [31:0] gr_r, gr_nxt;
  logic [1:0] st_r, st_nxt;
  logic [CW-1:0] hit_r, hit_nxt;
  logic [31:0] hsize_r, hsize_nxt;
  ffha_pkg::out_item_t result_r;

  logic        we;
  logic [IW-1:0] waddr, raddr;
  logic [32:0] wdata;
  logic        own_cur;
  logic [31:0] size_cur;
  logic [32:0] off_sum;

  assign own_cur  = rdata_r[32];
  assign size_cur = rdata_r[31:0];
  assign off_sum  = off_r + {1'b0, size_cur};

  always_comb begin
    stat = '0;
    stat.pre_fail = (req_r.request_size == 32'd0) ||
                    ((heap_size - total_r) < req_r.request_size);
    stat.scan_end = (idx_r >= count_r);
    stat.a_hit    = !own_cur && (size_cur >= req_r.request_size);
    stat.a_exact  = (size_cur == req_r.request_size);
    stat.a_full   = (count_r >= CW'(MAX_SEGMENTS));
    stat.sh_done  = (idx_r <= hit_r + CW'(1));
    stat.f_stop   = (off_r == {1'b0, req_r.release_offset}) ||
                    (off_sum > {1'b0, req_r.release_offset});
    stat.m_end    = (idx_r >= count_r);
  end

  always_comb begin
    count_nxt = count_r; total_nxt = total_r;
    idx_nxt = idx_r; wr_nxt = wr_r; off_nxt = off_r;
    acc_nxt = acc_r; acc_own_nxt = acc_own_r; acc_vld_nxt = acc_vld_r;
    gr_nxt = gr_r; st_nxt = st_r; hit_nxt = hit_r; hsize_nxt = hsize_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = idx_r[IW-1:0];
    if (cmd.init) begin
      count_nxt = CW'(1); total_nxt = '0;
      we = 1'b1; waddr = '0; wdata = {1'b0, heap_size};
    end
    if (cmd.start) begin
      idx_nxt = '0; off_nxt = '0; gr_nxt = '0;
      st_nxt = (in_item.req_type == ffha_pkg::REQ_FREE) ?
               ffha_pkg::ST_NOTFOUND : ffha_pkg::ST_NOSPACE;
    end
    if (cmd.a_check) begin
      if (!stat.a_hit) begin
        off_nxt = off_sum; idx_nxt = idx_r + CW'(1);
      end else begin
        hit_nxt = idx_r; hsize_nxt = size_cur; idx_nxt = count_r;
        if (stat.a_exact) begin
          we = 1'b1; waddr = idx_r[IW-1:0]; wdata = {1'b1, size_cur};
          total_nxt = total_r + req_r.request_size;
          gr_nxt = off_r[31:0]; st_nxt = ffha_pkg::ST_OK;
        end else if (stat.a_full) begin
          st_nxt = ffha_pkg::ST_FULL;
        end
      end
    end
    if (cmd.sh_rd) raddr = IW'(idx_r - CW'(1));
    if (cmd.sh_wr) begin
      we = 1'b1; waddr = idx_r[IW-1:0]; wdata = rdata_r;
      idx_nxt = idx_r - CW'(1);
    end
    if (cmd.a_resize) begin
      we = 1'b1; waddr = hit_r[IW-1:0];
      wdata = {1'b1, req_r.request_size};
    end
    if (cmd.a_fin) begin
      we = 1'b1; waddr = IW'(hit_r + CW'(1));
      wdata = {1'b0, hsize_r - req_r.request_size};
      hsize_nxt = req_r.request_size;
      count_nxt = count_r + CW'(1);
      total_nxt = total_r + req_r.request_size;
      gr_nxt = off_r[31:0]; st_nxt = ffha_pkg::ST_OK;
    end
    if (cmd.f_check) begin
      if (off_r == {1'b0, req_r.release_offset}) begin
        if (own_cur) begin
          we = 1'b1; waddr = idx_r[IW-1:0]; wdata = {1'b0, size_cur};
          total_nxt = total_r - size_cur;
          st_nxt = ffha_pkg::ST_OK;
        end
      end else begin
        off_nxt = off_sum; idx_nxt = idx_r + CW'(1);
      end
    end
    if (cmd.m_start) begin
      idx_nxt = '0; wr_nxt = '0; acc_vld_nxt = 1'b0;
    end
    if (cmd.m_step) begin
      idx_nxt = idx_r + CW'(1);
      if (acc_vld_r && !acc_own_r && !own_cur) begin
        acc_nxt = acc_r + size_cur;
      end else begin
        if (acc_vld_r) begin
          we = 1'b1; waddr = wr_r[IW-1:0]; wdata = {acc_own_r, acc_r};
          wr_nxt = wr_r + CW'(1);
        end
        acc_nxt = size_cur; acc_own_nxt = own_cur; acc_vld_nxt = 1'b1;
      end
    end
    if (cmd.m_flush) begin
      if (acc_vld_r) begin
        we = 1'b1; waddr = wr_r[IW-1:0]; wdata = {acc_own_r, acc_r};
        count_nxt = wr_r + CW'(1);
      end else begin
        count_nxt = wr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
    if (cmd.start) req_r <= in_item;
    idx_r <= idx_nxt; wr_r <= wr_nxt; off_r <= off_nxt;
    acc_r <= acc_nxt; acc_own_r <= acc_own_nxt; acc_vld_r <= acc_vld_nxt;
    gr_r <= gr_nxt; st_r <= st_nxt; hit_r <= hit_nxt; hsize_r <= hsize_nxt;
    if (cmd.load_out) begin
      result_r.granted_offset <= gr_r;
      result_r.status <= st_r;
      result_r.bytes_in_use <= total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(1); total_r <= '0;
    end else begin
      count_r <= count_nxt; total_r <= total_nxt;
    end
  end

  assign result = result_r;
endmodule

/* hdl/ffha_ctrl.sv */
// Controller of the first-fit heap allocator: sequences scans, shifts and
// merges over the datapath and runs the item handshakes. Uses ffha_pkg.
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  logic            cfg_wr,
  input  logic            req_free,
  input  ffha_pkg::stat_t stat,
  output ffha_pkg::cmd_t  cmd
);
  ffha_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffha_pkg::S_IDLE; out_valid_r <= 1'b0; init_r <= 1'b1;
    end else begin
      state_r <= state_nxt; out_valid_r <= out_valid_nxt; init_r <= 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.init = init_r || cfg_wr;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall = (state_r != ffha_pkg::S_IDLE) || init_r;
    case (state_r)
      ffha_pkg::S_IDLE: begin
        if (in_valid && !init_r) begin
          cmd.start = 1'b1;
          state_nxt = req_free ? ffha_pkg::S_F_RD : ffha_pkg::S_A_RD;
        end
      end
      ffha_pkg::S_A_RD: begin
        if (stat.pre_fail || stat.scan_end) state_nxt = ffha_pkg::S_DONE;
        else state_nxt = ffha_pkg::S_A_CHK;
      end
      ffha_pkg::S_A_CHK: begin
        cmd.a_check = 1'b1;
        if (!stat.a_hit) state_nxt = ffha_pkg::S_A_RD;
        else if (stat.a_exact || stat.a_full) state_nxt = ffha_pkg::S_DONE;
        else state_nxt = ffha_pkg::S_A_SHIFT_RD;
      end
      ffha_pkg::S_A_SHIFT_RD: begin
        if (stat.sh_done) begin
          cmd.a_resize = 1'b1; state_nxt = ffha_pkg::S_A_FIN;
        end else begin
          cmd.sh_rd = 1'b1; state_nxt = ffha_pkg::S_A_SHIFT_WR;
        end
      end
      ffha_pkg::S_A_SHIFT_WR: begin
        cmd.sh_wr = 1'b1; state_nxt = ffha_pkg::S_A_SHIFT_RD;
      end
      ffha_pkg::S_A_FIN: begin
        cmd.a_fin = 1'b1; state_nxt = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_F_RD: begin
        if (stat.scan_end) state_nxt = ffha_pkg::S_M_RD;
        else state_nxt = ffha_pkg::S_F_CHK;
      end
      ffha_pkg::S_F_CHK: begin
        cmd.f_check = 1'b1;
        if (stat.f_stop) begin
          cmd.m_start = 1'b1; state_nxt = ffha_pkg::S_M_RD;
        end else state_nxt = ffha_pkg::S_F_RD;
      end
      ffha_pkg::S_M_RD: begin
        if (stat.m_end) state_nxt = ffha_pkg::S_M_FLUSH;
        else state_nxt = ffha_pkg::S_M_STEP;
      end
      ffha_pkg::S_M_STEP: begin
        cmd.m_step = 1'b1; state_nxt = ffha_pkg::S_M_RD;
      end
      ffha_pkg::S_M_FLUSH: begin
        cmd.m_flush = 1'b1; state_nxt = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          out_valid_nxt = 1'b1; state_nxt = ffha_pkg::S_IDLE;
        end
      end
      default: state_nxt = ffha_pkg::S_IDLE;
    endcase
    // free scan that runs off the end still needs merge setup
    if (state_r == ffha_pkg::S_F_RD && stat.scan_end) cmd.m_start = 1'b1;
  end

  assign out_valid = out_valid_r;
endmodule

/* hdl/first_fit_heap_allocator.sv */
// First-fit heap allocator with coalescing, top level.
// Channels: in_* carries one request item (allocate or free), out_* one
//   result item per request; both use valid/stall. The p* signals form an APB-style
//   port with heap_size at address 0; writing it resets the table to one
//   free segment of heap_size bytes and clears bytes in use.
// Sequence: an allocate scans the entries in order up to the first fit and,
//   when it splits a segment, shifts the entries above the hit up to open a
//   slot; a free scans for the released offset and then runs a merge pass
//   over the whole table before the result. Each entry is read from the
//   segment memory through a registered read before it is checked.
// Throughput: one item at a time; in_stall is high while a request is in
//   work. The finished result sits in an output register, so the block
//   takes the next item while it waits; a new result waits until the held
//   one is taken.
// Reset: heap_size returns to 65536, one free segment, no result pending;
//   no item is taken in the first cycle after reset.
module first_fit_heap_allocator #(
  parameter int unsigned MAX_SEGMENTS = ffha_pkg::MaxSegments
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffha_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffha_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic [31:0] heap_size_r;
  logic cfg_wr;
  ffha_pkg::cmd_t cmd;
  ffha_pkg::stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = (paddr == 2'd0) ? heap_size_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) heap_size_r <= ffha_pkg::HeapSizeReset;
    else if (cfg_wr) heap_size_r <= pwdata;
  end

  ffha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cfg_wr(cfg_wr),
    .req_free(in_data.req_type), .stat(stat), .cmd(cmd)
  );

  ffha_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_item(in_data),
    .heap_size(cfg_wr ? pwdata : heap_size_r), .result(out_data)
  );
endmodule

/* tb/testbench.sv */
// Self-checking bench for the first-fit heap allocator: directed table, then
// random allocate/free traffic, checked against an in-bench segment table.
// Depends on ffha_pkg and first_fit_heap_allocator.
module testbench;

  localparam int NSEG = ffha_pkg::MaxSegments;
  localparam logic [1:0] ADDR_HEAP = 2'd0;

  typedef struct {
    logic        kind;
    logic [31:0] bytes;
    logic [31:0] off;
    bit          has_exp;
    logic [31:0] e_off;
    logic [1:0]  e_st;
    logic [31:0] e_use;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ffha_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ffha_pkg::out_item_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;

  first_fit_heap_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [31:0] heap_bytes;
  logic [31:0] seg_len [NSEG];
  bit          seg_own [NSEG];
  int          seg_cnt;
  logic [31:0] used_bytes;

  ffha_pkg::out_item_t grant_q [$];
  int errors = 0, n_out = 0, n_alloc_ok = 0, n_free_ok = 0, n_full = 0;

  function automatic void table_init(logic [31:0] hs);
    heap_bytes = hs;
    for (int i = 0; i < NSEG; i++) begin
      seg_len[i] = '0;
      seg_own[i] = 0;
    end
    seg_len[0] = hs;
    seg_cnt = 1;
    used_bytes = '0;
  endfunction

  function automatic void coalesce();
    int w;
    w = 0;
    for (int r = 0; r < seg_cnt; r++) begin
      if (w > 0 && !seg_own[w-1] && !seg_own[r]) begin
        seg_len[w-1] += seg_len[r];
      end else begin
        seg_len[w] = seg_len[r];
        seg_own[w] = seg_own[r];
        w++;
      end
    end
    for (int r = w; r < NSEG; r++) begin
      seg_len[r] = '0;
      seg_own[r] = 0;
    end
    seg_cnt = w;
  endfunction

  function automatic ffha_pkg::out_item_t predict_grant(ffha_pkg::in_item_t it);
    ffha_pkg::out_item_t res;
    logic [63:0] pos;
    bit done;
    res = '0;
    res.status = ffha_pkg::ST_NOSPACE;
    pos = '0;
    done = 0;
    if (it.req_type == ffha_pkg::REQ_ALLOC) begin
      if (it.request_size != 0 && (heap_bytes - used_bytes) >= it.request_size) begin
        for (int i = 0; i < seg_cnt && !done; i++) begin
          if (seg_own[i] || seg_len[i] < it.request_size) begin
            pos += seg_len[i];
          end else begin
            done = 1;
            if (seg_len[i] != it.request_size && seg_cnt >= NSEG) begin
              res.status = ffha_pkg::ST_FULL;
            end else begin
              if (seg_len[i] != it.request_size) begin
                for (int j = seg_cnt; j > i + 1; j--) begin
                  seg_len[j] = seg_len[j-1];
                  seg_own[j] = seg_own[j-1];
                end
                seg_len[i+1] = seg_len[i] - it.request_size;
                seg_own[i+1] = 0;
                seg_len[i] = it.request_size;
                seg_cnt++;
              end
              seg_own[i] = 1;
              used_bytes += it.request_size;
              res.status = ffha_pkg::ST_OK;
              res.granted_offset = pos[31:0];
            end
          end
        end
      end
    end else begin
      res.status = ffha_pkg::ST_NOTFOUND;
      for (int i = 0; i < seg_cnt && !done; i++) begin
        if (pos == {32'd0, it.release_offset}) begin
          if (seg_own[i]) begin
            seg_own[i] = 0;
            used_bytes -= seg_len[i];
            res.status = ffha_pkg::ST_OK;
          end
          done = 1;
        end else begin
          pos += seg_len[i];
          if (pos > {32'd0, it.release_offset}) done = 1;
        end
      end
      coalesce();
    end
    res.bytes_in_use = used_bytes;
    return res;
  endfunction

  // pick the start offset of a random owned segment, or a random offset in 0..64 if none
  function automatic logic [31:0] owned_start();
    logic [31:0] starts [$];
    logic [31:0] p;
    p = '0;
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_own[i]) starts.push_back(p);
      p += seg_len[i];
    end
    if (starts.size() == 0) return $urandom_range(0, 64);
    return starts[$urandom_range(0, starts.size() - 1)];
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result off=%h st=%0d use=%h", $time,
                 out_data.granted_offset, out_data.status, out_data.bytes_in_use);
        errors++;
      end else begin
        ffha_pkg::out_item_t e;
        e = grant_q.pop_front();
        if (e.granted_offset !== out_data.granted_offset) begin
          $display("%0t: granted_offset exp %h got %h", $time, e.granted_offset,
                   out_data.granted_offset);
          errors++;
        end
        if (e.status !== out_data.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
          errors++;
        end
        if (e.bytes_in_use !== out_data.bytes_in_use) begin
          $display("%0t: bytes_in_use exp %h got %h", $time, e.bytes_in_use,
                   out_data.bytes_in_use);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  task automatic cfg_write(logic [31:0] hs);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_HEAP; pwdata <= hs;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    table_init(hs);
  endtask

  task automatic drain();
    while (grant_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  int burst_left = 0;

  task automatic send_item(ffha_pkg::in_item_t it, bit has_exp,
                           ffha_pkg::out_item_t exp_res);
    ffha_pkg::out_item_t pred;
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    pred = predict_grant(it);
    if (has_exp && pred !== exp_res) begin
      $display("%0t: table row exp off=%h st=%0d use=%h, model off=%h st=%0d use=%h",
               $time, exp_res.granted_offset, exp_res.status, exp_res.bytes_in_use,
               pred.granted_offset, pred.status, pred.bytes_in_use);
      errors++;
    end
    if (pred.status == ffha_pkg::ST_OK && it.req_type == ffha_pkg::REQ_ALLOC)
      n_alloc_ok++;
    if (pred.status == ffha_pkg::ST_OK && it.req_type == ffha_pkg::REQ_FREE)
      n_free_ok++;
    if (pred.status == ffha_pkg::ST_FULL) n_full++;
    grant_q.push_back(has_exp ? exp_res : pred);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  row_t rows [$];

  function automatic row_t mk(logic k, logic [31:0] b, logic [31:0] o, bit he = 0,
                              logic [31:0] eo = 0, logic [1:0] es = 0,
                              logic [31:0] eu = 0);
    row_t r;
    r.kind = k; r.bytes = b; r.off = o; r.has_exp = he;
    r.e_off = eo; r.e_st = es; r.e_use = eu;
    return r;
  endfunction

  initial begin
    ffha_pkg::in_item_t it;
    ffha_pkg::out_item_t ex;
    int heap_mode;
    table_init(ffha_pkg::HeapSizeReset);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back(mk(ffha_pkg::REQ_ALLOC, 0, 0, 1, 0, ffha_pkg::ST_NOSPACE, 0));
    rows.push_back(mk(ffha_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 0, 1, 0,
                      ffha_pkg::ST_NOSPACE, 0));
    rows.push_back(mk(ffha_pkg::REQ_FREE, 0, 0, 1, 0, ffha_pkg::ST_NOTFOUND, 0));
    rows.push_back(mk(ffha_pkg::REQ_ALLOC, 100, 32'hFFFF_FFFF, 1, 0,
                      ffha_pkg::ST_OK, 100));
    rows.push_back(mk(ffha_pkg::REQ_ALLOC, 200, 0, 1, 100, ffha_pkg::ST_OK, 300));
    rows.push_back(mk(ffha_pkg::REQ_ALLOC, 300, 0, 1, 300, ffha_pkg::ST_OK, 600));
    rows.push_back(mk(ffha_pkg::REQ_FREE, 0, 50));
    rows.push_back(mk(ffha_pkg::REQ_FREE, 0, 100, 1, 0, ffha_pkg::ST_OK, 400));
    rows.push_back(mk(ffha_pkg::REQ_FREE, 0, 100, 1, 0, ffha_pkg::ST_NOTFOUND, 400));
    rows.push_back(mk(ffha_pkg::REQ_ALLOC, 200, 0, 1, 100, ffha_pkg::ST_OK, 600));
    rows.push_back(mk(ffha_pkg::REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0,
                      ffha_pkg::ST_NOTFOUND, 600));
    rows.push_back(mk(ffha_pkg::REQ_ALLOC, 64936, 0, 1, 600, ffha_pkg::ST_OK, 65536));
    rows.push_back(mk(ffha_pkg::REQ_ALLOC, 1, 0, 1, 0, ffha_pkg::ST_NOSPACE, 65536));
    rows.push_back(mk(ffha_pkg::REQ_FREE, 0, 300));
    rows.push_back(mk(ffha_pkg::REQ_FREE, 0, 100));
    rows.push_back(mk(ffha_pkg::REQ_FREE, 0, 600));
    rows.push_back(mk(ffha_pkg::REQ_FREE, 0, 0));
    rows.push_back(mk(ffha_pkg::REQ_ALLOC, 65536, 0, 1, 0, ffha_pkg::ST_OK, 65536));
    rows.push_back(mk(ffha_pkg::REQ_FREE, 0, 0, 1, 0, ffha_pkg::ST_OK, 0));
    foreach (rows[i]) begin
      it.req_type = rows[i].kind;
      it.request_size = rows[i].bytes;
      it.release_offset = rows[i].off;
      ex.granted_offset = rows[i].e_off;
      ex.status = rows[i].e_st;
      ex.bytes_in_use = rows[i].e_use;
      send_item(it, rows[i].has_exp, ex);
    end
    idle_input();
    drain();

    // zero heap, then table-full with the maximum heap
    cfg_write(32'd0);
    it = '{ffha_pkg::REQ_ALLOC, 32'd1, 32'd0};
    send_item(it, 1, '{32'd0, ffha_pkg::ST_NOSPACE, 32'd0});
    idle_input();
    drain();
    cfg_write(32'hFFFF_FFFF);
    for (int i = 0; i < NSEG + 2; i++) begin
      it = '{ffha_pkg::REQ_ALLOC, 32'd1 << (i % 20), $urandom};
      send_item(it, 0, '0);
    end
    it = '{ffha_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 32'd0};
    send_item(it, 0, '0);
    idle_input();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      heap_mode = ph % 4;
      case (heap_mode)
        0: cfg_write(32'd1);
        1: cfg_write($urandom_range(256, 4096));
        2: cfg_write(32'hFFFF_FFFF);
        default: cfg_write($urandom);
      endcase
      for (int n = 0; n < 240; n++) begin
        int pick;
        pick = $urandom_range(0, 99);
        it.request_size = $urandom;
        it.release_offset = $urandom;
        if (pick < 50) begin
          it.req_type = ffha_pkg::REQ_ALLOC;
          case ($urandom_range(0, 3))
            0: it.request_size = $urandom_range(1, 8);
            1: it.request_size = $urandom_range(1, (heap_bytes >> 6) + 1);
            2: it.request_size = $urandom_range(1, (heap_bytes >> 3) + 1);
            default: it.request_size = $urandom;
          endcase
        end else if (pick < 90) begin
          it.req_type = ffha_pkg::REQ_FREE;
          it.release_offset = owned_start();
        end else begin
          it.req_type = logic'($urandom_range(0, 1));
        end
        send_item(it, 0, '0);
        if (n == 120) begin
          idle_input();
          while (grant_q.size() != 0) @(posedge clk);
        end
      end
      idle_input();
      drain();
    end

    $display("Covered %0d results: %0d allocations, %0d releases, %0d table-full hits",
             n_out, n_alloc_ok, n_free_ok, n_full);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
hdl/ffha_pkg.sv
hdl/ffha_datapath.sv
hdl/ffha_ctrl.sv
hdl/first_fit_heap_allocator.sv
tb/testbench.sv
